FILE: hw/rtl/bde_pkg.sv
// shared types for the bounded deque engine
// command and status codes, controller to datapath command struct, datapath to controller status struct
`default_nettype none

package bde_pkg;

  localparam int unsigned DEPTH_DEF     = 256;
  localparam int unsigned WORD_BITS_DEF = 32;

  localparam int unsigned CMD_BITS    = 3;
  localparam int unsigned VALUE_BITS  = 32;
  localparam int unsigned POS_BITS    = 8;
  localparam int unsigned COUNT_BITS  = 9;
  localparam int unsigned STATUS_BITS = 2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_READ       = 3'd4,
    CMD_CONTAINS   = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic scan;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic empty;
    logic range_err;
    logic scan_done;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bde_ctrl.sv
// sequencing state machine for the bounded deque engine
// depends on bde_pkg; drives the datapath through dp_cmd_t, reads dp_stat_t
`default_nettype none

module bde_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_stall_o,
  output bde_pkg::dp_cmd_t cmd_o,
  input  bde_pkg::dp_stat_t stat_i
);
  import bde_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WAIT,
    S_SCAN,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        case (stat_i.cmd)
          CMD_POP_FRONT, CMD_POP_BACK: state_d = stat_i.empty ? S_DONE : S_WAIT;
          CMD_READ:                    state_d = stat_i.range_err ? S_DONE : S_WAIT;
          CMD_CONTAINS:                state_d = S_SCAN;
          default:                     state_d = S_DONE;
        endcase
      end
      S_WAIT: begin
        state_d = S_DONE;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

FILE: hw/rtl/bde_dp.sv
// datapath of the bounded deque engine: ring store, pointers, scan and result register
// depends on bde_pkg; steered by bde_ctrl
`default_nettype none

module bde_dp #(
  parameter int unsigned DEPTH     = bde_pkg::DEPTH_DEF,
  parameter int unsigned WORD_BITS = bde_pkg::WORD_BITS_DEF
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire        [bde_pkg::CMD_BITS-1:0]     command_i,
  input  wire signed [bde_pkg::VALUE_BITS-1:0]   value_i,
  input  wire        [bde_pkg::POS_BITS-1:0]     position_i,
  input  bde_pkg::dp_cmd_t                       cmd_i,
  output bde_pkg::dp_stat_t                      stat_o,
  output logic                                   out_valid_o,
  input  wire                                    out_stall_i,
  output logic signed [bde_pkg::VALUE_BITS-1:0]  word_o,
  output logic                                   found_o,
  output logic       [bde_pkg::COUNT_BITS-1:0]   count_o,
  output logic       [bde_pkg::STATUS_BITS-1:0]  status_o
);
  import bde_pkg::*;

  localparam int unsigned PW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned SW   = CW + 1;
  localparam int unsigned CMPW = (CW > POS_BITS) ? CW : POS_BITS;

  function automatic logic [PW-1:0] ring_slot(input logic [PW-1:0] f, input logic [CW-1:0] k);
    logic [SW-1:0] s;
    s = SW'(f) + SW'(k);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return PW'(s);
  endfunction

  logic [WORD_BITS-1:0] mem_q [DEPTH];
  logic [WORD_BITS-1:0] rd_data_q;

  logic [PW-1:0]        front_q, front_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        idx_q, idx_d;
  cmd_e                 cmd_q;
  logic [WORD_BITS-1:0] val_q;
  logic [POS_BITS-1:0]  pos_q;
  status_e              status_q, status_d;
  logic                 wsel_q, wsel_d;
  logic                 hit_q, hit_d;
  logic                 rd_pend_q;
  logic                 out_valid_q;

  logic                 full, empty, range_err;
  logic                 we, re, issue;
  logic [PW-1:0]        wa, ra, front_dec, front_inc;

  assign full      = (count_q == CW'(DEPTH));
  assign empty     = (count_q == '0);
  assign range_err = (CMPW'(pos_q) >= CMPW'(count_q));
  assign front_dec = (front_q == '0) ? PW'(DEPTH - 1) : front_q - PW'(1);
  assign front_inc = (front_q == PW'(DEPTH - 1)) ? '0 : front_q + PW'(1);

  assign hit_d = cmd_i.load ? 1'b0 :
                 (hit_q | (cmd_i.scan & rd_pend_q & (rd_data_q == val_q)));
  assign issue = cmd_i.scan & (idx_q < count_q) & ~hit_d;
  assign idx_d = cmd_i.exec ? '0 : (issue ? idx_q + CW'(1) : idx_q);

  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    status_d = status_q;
    wsel_d   = wsel_q;
    we       = 1'b0;
    wa       = ring_slot(front_q, count_q);
    re       = issue;
    ra       = ring_slot(front_q, idx_q);
    if (cmd_i.exec) begin
      status_d = ST_OK;
      wsel_d   = 1'b0;
      case (cmd_q)
        CMD_PUSH_FRONT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            we      = 1'b1;
            wa      = front_dec;
            front_d = front_dec;
            count_d = count_q + CW'(1);
          end
        end
        CMD_PUSH_BACK: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            we      = 1'b1;
            count_d = count_q + CW'(1);
          end
        end
        CMD_POP_FRONT: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            re      = 1'b1;
            ra      = front_q;
            wsel_d  = 1'b1;
            front_d = front_inc;
            count_d = count_q - CW'(1);
          end
        end
        CMD_POP_BACK: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            re      = 1'b1;
            ra      = ring_slot(front_q, count_q - CW'(1));
            wsel_d  = 1'b1;
            count_d = count_q - CW'(1);
          end
        end
        CMD_READ: begin
          if (range_err) begin
            status_d = ST_RANGE;
          end else begin
            re     = 1'b1;
            ra     = ring_slot(front_q, CW'(pos_q));
            wsel_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= val_q;
    end
    if (re) begin
      rd_data_q <= mem_q[ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      front_q   <= front_d;
      count_q   <= count_d;
      rd_pend_q <= issue;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= cmd_e'(command_i);
      val_q <= WORD_BITS'(value_i);
      pos_q <= position_i;
    end
    idx_q    <= idx_d;
    hit_q    <= hit_d;
    status_q <= status_d;
    wsel_q   <= wsel_d;
    if (cmd_i.finish) begin
      word_o   <= wsel_q ? VALUE_BITS'($signed(rd_data_q)) : '0;
      found_o  <= hit_q;
      count_o  <= COUNT_BITS'(count_q);
      status_o <= status_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign stat_o.cmd       = cmd_q;
  assign stat_o.empty     = empty;
  assign stat_o.range_err = range_err;
  assign stat_o.scan_done = cmd_i.scan & ~issue & ~rd_pend_q;
  assign stat_o.out_free  = ~out_valid_q | ~out_stall_i;

endmodule

`default_nettype wire

FILE: hw/rtl/bounded_deque_engine_top.sv
// top level of the bounded deque engine
// depends on bde_pkg; instantiates bde_ctrl and bde_dp
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_stall_o   command_i, value_i, position_i
//   out      output     out_valid_o / out_stall_i word_o, found_o, count_o, status_o
//
// one command is worked at a time: push and error cases pass through load, exec and done,
// pop and read add a wait step, contains scans with one ring store read per element until a match
// reset empties the deque at once; the ring store itself is not cleared
// a waiting result sits in the output register, so the next command can transfer
// while out_stall_i is high; only the step that loads the result waits for it
`default_nettype none

module bounded_deque_engine_top #(
  parameter int unsigned DEPTH     = bde_pkg::DEPTH_DEF,
  parameter int unsigned WORD_BITS = bde_pkg::WORD_BITS_DEF
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    in_valid_i,
  output logic                                   in_stall_o,
  input  wire        [bde_pkg::CMD_BITS-1:0]     command_i,
  input  wire signed [bde_pkg::VALUE_BITS-1:0]   value_i,
  input  wire        [bde_pkg::POS_BITS-1:0]     position_i,
  output logic                                   out_valid_o,
  input  wire                                    out_stall_i,
  output logic signed [bde_pkg::VALUE_BITS-1:0]  word_o,
  output logic                                   found_o,
  output logic       [bde_pkg::COUNT_BITS-1:0]   count_o,
  output logic       [bde_pkg::STATUS_BITS-1:0]  status_o
);
  import bde_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  bde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (dp_cmd),
    .stat_i     (dp_stat)
  );

  bde_dp #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .command_i   (command_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .word_o      (word_o),
    .found_o     (found_o),
    .count_o     (count_o),
    .status_o    (status_o)
  );

endmodule

`default_nettype wire
